// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent checks used in this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// ===== rtl/dnle_pkg.sv =====
// ----------------------------------------------------------------------------
// dnle_pkg
// Shared types and constants of the name label encoder.
// ----------------------------------------------------------------------------
package dnle_pkg;

	localparam logic [7:0] CH_END = 8'h00;
	localparam logic [7:0] CH_DOT = 8'h2e;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_NAME_LONG  = 2'd1;
	localparam logic [1:0] STATUS_LABEL_LONG = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT,
		ST_STATUS
	} dnle_state_t;

	typedef struct packed {
		logic accept;
		logic step;
		logic push_status;
	} dnle_cmd_t;

	typedef struct packed {
		logic is_zero;
		logic is_dot;
		logic dot_emits;
		logic end_ok;
		logic byte_completes;
		logic byte_final;
		logic out_free;
	} dnle_stat_t;

endpackage

// ===== rtl/dnle_ram.sv =====
// ----------------------------------------------------------------------------
// dnle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dnle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 63
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/dnle_ctrl.sv =====
// ----------------------------------------------------------------------------
// dnle_ctrl
// Controller: takes characters, runs label emission and the status result.
// ----------------------------------------------------------------------------
module dnle_ctrl import dnle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dnle_stat_t stat,
	output dnle_cmd_t  cmd
);

	dnle_state_t state_q;
	dnle_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_stall   = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (stat.is_zero) begin
						state_next = stat.end_ok ? ST_EMIT : ST_STATUS;
					end else if (stat.is_dot && stat.dot_emits) begin
						state_next = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				// hold while a finished pair cannot enter the output register
				if (!(stat.byte_completes && !stat.out_free)) begin
					cmd.step = 1'b1;
					if (stat.byte_final) begin
						state_next = ST_IDLE;
					end
				end
			end
			ST_STATUS: begin
				if (stat.out_free) begin
					cmd.push_status = 1'b1;
					state_next      = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/dnle_dp.sv =====
// ----------------------------------------------------------------------------
// dnle_dp
// Datapath: label buffer, length counters, byte sequencer and output register.
// ----------------------------------------------------------------------------
module dnle_dp import dnle_pkg::*; #(
	parameter int MAX_LABEL = 63,
	parameter int MAX_NAME  = 253
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] ch,
	input  dnle_cmd_t  cmd,
	output dnle_stat_t stat,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] byte_first,
	output logic [7:0] byte_second,
	output logic [1:0] byte_count,
	output logic       name_done,
	output logic [1:0] status,
	output logic       last
);

	localparam int LW = $clog2(MAX_LABEL + 1);
	localparam int NW = $clog2(MAX_NAME + 2);
	localparam int JW = $clog2(MAX_LABEL + 2);
	localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

	logic [LW-1:0] label_len_q;
	logic [NW-1:0] name_chars_q;
	logic          label_err_q;
	logic          done_q;
	logic [JW-1:0] idx_q;
	logic [1:0]    status_q;
	logic [7:0]    half_q;
	logic          out_valid_q;
	logic [7:0]    first_q;
	logic [7:0]    second_q;
	logic [1:0]    count_q;
	logic          done_out_q;
	logic [1:0]    status_out_q;
	logic          last_q;

	logic [NW-1:0] name_inc;
	logic [1:0]    end_status;
	logic [JW-1:0] len_j;
	logic [JW-1:0] last_idx;
	logic [7:0]    cur_byte;
	logic          label_room;
	logic          is_zero;
	logic          is_dot;
	logic          byte_final;
	logic          byte_completes;
	logic          out_load;
	logic          wr_en;
	logic          rd_en;
	logic [7:0]    rd_data;

	assign is_zero    = (ch == CH_END);
	assign is_dot     = (ch == CH_DOT);
	assign name_inc   = (name_chars_q <= NW'(MAX_NAME)) ? name_chars_q + NW'(1) : name_chars_q;
	assign label_room = (label_len_q < LW'(MAX_LABEL));

	always_comb begin
		if (name_chars_q > NW'(MAX_NAME)) begin
			end_status = STATUS_NAME_LONG;
		end else if (label_err_q) begin
			end_status = STATUS_LABEL_LONG;
		end else begin
			end_status = STATUS_OK;
		end
	end

	// byte stream: length byte, label characters, then the closing zero at the end of a name
	assign len_j    = JW'(label_len_q);
	assign last_idx = len_j + JW'(done_q);

	always_comb begin
		if (idx_q == '0) begin
			cur_byte = 8'(label_len_q);
		end else if (idx_q <= len_j) begin
			cur_byte = rd_data;
		end else begin
			cur_byte = 8'h00;
		end
	end

	assign byte_final     = (idx_q == last_idx);
	assign byte_completes = idx_q[0] | byte_final;

	assign stat.is_zero        = is_zero;
	assign stat.is_dot         = is_dot;
	assign stat.dot_emits      = (name_inc <= NW'(MAX_NAME)) && !label_err_q;
	assign stat.end_ok         = (end_status == STATUS_OK);
	assign stat.byte_completes = byte_completes;
	assign stat.byte_final     = byte_final;
	assign stat.out_free       = !out_valid_q || !out_stall;

	assign wr_en    = cmd.accept && !is_zero && !is_dot && label_room;
	assign rd_en    = cmd.step && (idx_q < len_j);
	assign out_load = (cmd.step && byte_completes) || cmd.push_status;

	dnle_ram #(
		.WIDTH (8),
		.DEPTH (MAX_LABEL)
	) u_label_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(label_len_q)),
		.wr_data (ch),
		.rd_en   (rd_en),
		.rd_addr (AW'(idx_q)),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_len_q  <= '0;
			name_chars_q <= '0;
			label_err_q  <= 1'b0;
			done_q       <= 1'b0;
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.accept) begin
				if (is_zero) begin
					if (end_status == STATUS_OK) begin
						idx_q  <= '0;
						done_q <= 1'b1;
					end else begin
						label_len_q  <= '0;
						name_chars_q <= '0;
						label_err_q  <= 1'b0;
					end
				end else if (is_dot) begin
					name_chars_q <= name_inc;
					if (stat.dot_emits) begin
						idx_q  <= '0;
						done_q <= 1'b0;
					end else begin
						label_len_q <= '0;
					end
				end else begin
					name_chars_q <= name_inc;
					if (label_room) begin
						label_len_q <= label_len_q + LW'(1);
					end else begin
						label_err_q <= 1'b1;
					end
				end
			end
			if (cmd.step) begin
				if (byte_final) begin
					label_len_q <= '0;
					if (done_q) begin
						name_chars_q <= '0;
						label_err_q  <= 1'b0;
					end
				end else begin
					idx_q <= idx_q + JW'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && is_zero) begin
			status_q <= end_status;
		end
		if (cmd.step && !byte_completes) begin
			half_q <= cur_byte;
		end
		if (cmd.step && byte_completes) begin
			if (idx_q[0]) begin
				first_q  <= half_q;
				second_q <= cur_byte;
				count_q  <= 2'd2;
			end else begin
				first_q  <= cur_byte;
				second_q <= 8'h00;
				count_q  <= 2'd1;
			end
			done_out_q   <= byte_final && done_q;
			status_out_q <= STATUS_OK;
			last_q       <= byte_final;
		end else if (cmd.push_status) begin
			first_q      <= 8'h00;
			second_q     <= 8'h00;
			count_q      <= 2'd0;
			done_out_q   <= 1'b1;
			status_out_q <= status_q;
			last_q       <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign byte_first  = first_q;
	assign byte_second = second_q;
	assign byte_count  = count_q;
	assign name_done   = done_out_q;
	assign status      = status_out_q;
	assign last        = last_q;

endmodule

// ===== rtl/dns_name_label_encoder_core.sv =====
// ----------------------------------------------------------------------------
// dns_name_label_encoder_core
// Encodes a dotted host name, one character per transfer and ended by a zero
// byte, into length-prefixed labels packed two bytes per output transfer. An
// ordinary character is taken without a stall and is written into the label
// buffer while the label has room. A dot or the end byte then holds the input
// while each encoded byte is produced in turn (length byte, label characters
// and, at the end of a name, the closing zero), since the label buffer has a
// single read port read one byte a cycle; each finished pair waits only when
// the output register is still occupied. A dot after an error is taken
// without a stall and emits nothing. An end byte after an error holds the
// input until the output register is free and yields a single status-only
// transfer; the receiver then discards the bytes that name produced earlier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dns_name_label_encoder_core import dnle_pkg::*; #(
	parameter int MAX_LABEL = 63,
	parameter int MAX_NAME  = 253
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] ch,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] byte_first,
	output logic [7:0] byte_second,
	output logic [1:0] byte_count,
	output logic       name_done,
	output logic [1:0] status,
	output logic       last
);

	dnle_cmd_t  cmd;
	dnle_stat_t stat;

	dnle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	dnle_dp #(
		.MAX_LABEL (MAX_LABEL),
		.MAX_NAME  (MAX_NAME)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ch          (ch),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.byte_first  (byte_first),
		.byte_second (byte_second),
		.byte_count  (byte_count),
		.name_done   (name_done),
		.status      (status),
		.last        (last)
	);

	// a result without bytes only ever carries an error status at the end of a name
	`ASSERT_IMPL(a_empty_is_error, clk, arst_n, out_valid && (byte_count == 2'd0), name_done && (status != STATUS_OK))
	// the end of a name is always the last result of its character
	`ASSERT_IMPL(a_done_is_last, clk, arst_n, out_valid && name_done, last)
	// an accepted end byte never lets the next character in on the following cycle
	`ASSERT_NEXT(a_end_blocks_input, clk, arst_n, in_valid && !in_stall && (ch == CH_END), in_stall)

endmodule

// ===== tb/sv/dnle_encode_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dnle_encode_checker
// Watches both channels of the name label encoder. Each new character on the
// input is run through a local label encoder that holds its own label buffer
// and lengths. The expected output transfers it queues are compared, field by
// field, in order, with the transfers that the block delivers. It reports
// counts of failures, outstanding words and names seen to the top level.
// ----------------------------------------------------------------------------
module dnle_encode_checker import dnle_pkg::*; #(
	parameter int MAX_LABEL = 63,
	parameter int MAX_NAME  = 253
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] ch,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] byte_first,
	input  logic [7:0] byte_second,
	input  logic [1:0] byte_count,
	input  logic       name_done,
	input  logic [1:0] status,
	input  logic       last,
	output int         fails,
	output int         pending,
	output int         names_seen,
	output int         names_flagged,
	output int         words_seen
);

	typedef struct packed {
		logic [7:0] b_first;
		logic [7:0] b_second;
		logic [1:0] count;
		logic       done;
		logic [1:0] st;
		logic       lst;
	} enc_word_t;

	enc_word_t  expected_words[$];
	logic [7:0] enc_bytes[$];
	logic [7:0] label_buf [MAX_LABEL];
	int         label_len;
	int         name_chars;
	bit         label_bad;
	bit         item_predicted;
	int         fail_cnt;
	int         name_cnt;
	int         flagged_cnt;
	int         word_cnt;

	task automatic load_label();
		enc_bytes.push_back(label_len[7:0]);
		for (int i = 0; i < label_len; i++)
			enc_bytes.push_back(label_buf[i]);
	endtask

	// splits enc_bytes into two-byte words
	task automatic queue_words(input bit done, input logic [1:0] st);
		int        cnt;
		int        pos;
		int        have;
		enc_word_t w;
		cnt = (enc_bytes.size() + 1) / 2;
		if (cnt == 0 && !done)
			return;
		if (cnt == 0)
			cnt = 1;
		for (int k = 0; k < cnt; k++) begin
			pos = 2 * k;
			have = (pos < enc_bytes.size()) ? ((enc_bytes.size() - pos >= 2) ? 2 : 1) : 0;
			w.b_first  = (have >= 1) ? enc_bytes[pos] : 8'h00;
			w.b_second = (have == 2) ? enc_bytes[pos + 1] : 8'h00;
			w.count    = have[1:0];
			w.lst      = (k == cnt - 1);
			w.done     = w.lst && done;
			w.st       = w.done ? st : STATUS_OK;
			expected_words.push_back(w);
		end
	endtask

	task automatic encode_char(input logic [7:0] c);
		logic [1:0] st;
		enc_bytes.delete();
		if (c == CH_END) begin
			st = (name_chars > MAX_NAME) ? STATUS_NAME_LONG :
				(label_bad ? STATUS_LABEL_LONG : STATUS_OK);
			if (st == STATUS_OK) begin
				load_label();
				enc_bytes.push_back(8'h00);
			end
			queue_words(1'b1, st);
			label_len  = 0;
			name_chars = 0;
			label_bad  = 1'b0;
		end else begin
			if (name_chars <= MAX_NAME)
				name_chars++;
			if (c == CH_DOT) begin
				if (name_chars <= MAX_NAME && !label_bad) begin
					load_label();
					queue_words(1'b0, STATUS_OK);
				end
				label_len = 0;
			end else if (label_len < MAX_LABEL) begin
				label_buf[label_len] = c;
				label_len++;
			end else begin
				label_bad = 1'b1;
			end
		end
	endtask

	task automatic check_field(input string fname, input logic [7:0] exp_v,
		input logic [7:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", fname, exp_v, act_v);
			fail_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		enc_word_t w;
		if (!arst_n) begin
			expected_words.delete();
			label_len      = 0;
			name_chars     = 0;
			label_bad      = 1'b0;
			item_predicted = 1'b0;
			fail_cnt       = 0;
			name_cnt       = 0;
			flagged_cnt    = 0;
			word_cnt       = 0;
			fails         <= 0;
			pending       <= 0;
			names_seen    <= 0;
			names_flagged <= 0;
			words_seen    <= 0;
		end else begin
			// predict as soon as a character is offered, since its words may
			// leave before the input transfer completes
			if (in_valid && !item_predicted) begin
				encode_char(ch);
				item_predicted = 1'b1;
			end
			if (in_valid && !in_stall)
				item_predicted = 1'b0;
			if (out_valid && !out_stall) begin
				word_cnt++;
				if (expected_words.size() == 0) begin
					$error("unexpected output transfer: count %0d, bytes %0d %0d",
						byte_count, byte_first, byte_second);
					fail_cnt++;
				end else begin
					w = expected_words.pop_front();
					check_field("byte_first", w.b_first, byte_first);
					check_field("byte_second", w.b_second, byte_second);
					check_field("byte_count", {6'd0, w.count}, {6'd0, byte_count});
					check_field("name_done", {7'd0, w.done}, {7'd0, name_done});
					check_field("status", {6'd0, w.st}, {6'd0, status});
					check_field("last", {7'd0, w.lst}, {7'd0, last});
					if (w.done) begin
						name_cnt++;
						if (w.st != STATUS_OK)
							flagged_cnt++;
					end
				end
			end
			fails         <= fail_cnt;
			pending       <= expected_words.size();
			names_seen    <= name_cnt;
			names_flagged <= flagged_cnt;
			words_seen    <= word_cnt;
		end
	end

endmodule

// ===== tb/sv/tb_dns_name_label_encoder_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dns_name_label_encoder_core
// Drives host names into the label encoder one character per transfer: first
// hand-picked names (empty labels, the label and name length limits, both
// error kinds together), then random names, overlong names and noise. Both
// sides insert random wait cycles. The checker predicts and compares; this
// module gives the verdict.
// ----------------------------------------------------------------------------
module tb_dns_name_label_encoder_core;
	import dnle_pkg::*;

	logic       clk;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_stall;
	logic [7:0] ch          = 8'h00;
	logic       out_valid;
	logic       out_stall   = 1'b0;
	logic [7:0] byte_first;
	logic [7:0] byte_second;
	logic [1:0] byte_count;
	logic       name_done;
	logic [1:0] status;
	logic       last;

	int fails;
	int pending;
	int names_seen;
	int names_flagged;
	int words_seen;
	int chars_sent = 0;
	int in_mode    = 1;
	int out_mode   = 1;

	dns_name_label_encoder_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.ch          (ch),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.byte_first  (byte_first),
		.byte_second (byte_second),
		.byte_count  (byte_count),
		.name_done   (name_done),
		.status      (status),
		.last        (last)
	);

	dnle_encode_checker encode_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.ch            (ch),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.byte_first    (byte_first),
		.byte_second   (byte_second),
		.byte_count    (byte_count),
		.name_done     (name_done),
		.status        (status),
		.last          (last),
		.fails         (fails),
		.pending       (pending),
		.names_seen    (names_seen),
		.names_flagged (names_flagged),
		.words_seen    (words_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// mode 0 never waits, 1 waits now and then, 2 waits often
	function automatic int pick_wait(input int mode);
		if (mode == 0)
			return 0;
		if (mode == 1)
			return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
		return $urandom_range(0, 14);
	endfunction

	function automatic logic [7:0] label_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c == CH_DOT);
		return c;
	endfunction

	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = pick_wait(in_mode);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic send_label(input int n);
		repeat (n) send_char(label_char());
	endtask

	// n_labels labels joined by dots, the last one of its own length
	task automatic send_dotted(input int n_labels, input int len_each, input int len_last);
		for (int i = 0; i < n_labels - 1; i++) begin
			send_label(len_each);
			send_char(CH_DOT);
		end
		send_label(len_last);
	endtask

	task automatic send_random_name();
		int kind;
		int n_labels;
		int n;
		kind = $urandom_range(0, 99);
		if (kind < 72) begin
			n_labels = $urandom_range(1, 4);
			for (int i = 0; i < n_labels; i++) begin
				if (i > 0)
					send_char(CH_DOT);
				n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 10);
				send_label(n);
			end
			if ($urandom_range(0, 7) == 0)
				send_char(CH_DOT);
		end else if (kind < 74) begin
			send_dotted($urandom_range(4, 5), $urandom_range(55, 63), $urandom_range(0, 63));
		end else begin
			n = $urandom_range(1, 20);
			repeat (n) begin
				case ($urandom_range(0, 15))
					0: send_char(CH_DOT);
					1: send_char(CH_END);
					default: send_char(label_char());
				endcase
			end
		end
		send_char(CH_END);
	endtask

	// output side
	initial begin : drain
		int hold;
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				out_mode = $urandom_range(0, 2);
			hold = pick_wait(out_mode);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	initial begin : stimulus
		int guard;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty name, lone dot, double and trailing dots, leading dot
		send_char(CH_END);
		send_text(".");
		send_char(CH_END);
		send_text("a..b.");
		send_char(CH_END);
		send_text(".x");
		send_char(CH_END);
		send_char(8'hff);
		send_char(8'h01);
		send_char(8'h80);
		send_char(8'h7f);
		send_char(CH_END);
		// one char too many in a label with a dot after it
		send_label(64);
		send_char(CH_DOT);
		send_label(3);
		send_char(CH_END);
		// longest labels, a dot landing exactly on the name limit, then both errors
		send_dotted(4, 63, 60);
		send_char(CH_DOT);
		send_label(64);
		send_char(CH_END);

		while (chars_sent < 480) begin
			if ($urandom_range(0, 5) == 0)
				in_mode = $urandom_range(0, 2);
			send_random_name();
		end
		in_valid <= 1'b0;

		guard = 0;
		while (pending != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (40) @(posedge clk);

		$display("sent %0d characters in %0d names, %0d of them rejected", chars_sent,
			names_seen, names_flagged);
		$display("received %0d encoded output transfers", words_seen);
		if (fails == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			if (pending != 0)
				$error("%0d expected output transfers never arrived", pending);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dnle_pkg.sv
rtl/dnle_ram.sv
rtl/dnle_ctrl.sv
rtl/dnle_dp.sv
rtl/dns_name_label_encoder_core.sv
tb/sv/dnle_encode_checker.sv
tb/sv/tb_dns_name_label_encoder_core.sv
